// ----- hdl/mbps_pkg.sv -----
// Shared types and constants for the masked byte pattern search block.
// Used by the window cells, the result skid buffer and the top level.
// No dependencies.
package mbps_pkg;

	// Default depth of the byte window.
	localparam int MaxPattern = 24;
	// Number of pattern byte slots held in the registers.
	localparam int PatternSlots = 24;
	// Width of the pattern length register.
	localparam int LenW = 5;
	// Width of the byte offset counter.
	localparam int PosW = 32;
	// Width of addresses and of the wide registers.
	localparam int AddrW = 64;
	// Width of the configuration register index.
	localparam int CfgIdxW = 3;
	// Width of the care mask register.
	localparam int CareW = 24;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		RegPatternA = 3'd0,
		RegPatternB = 3'd1,
		RegPatternC = 3'd2,
		RegCareMask = 3'd3,
		RegPatternLen = 3'd4,
		RegRegionBase = 3'd5
	} cfg_reg_t;

	// All pattern bytes, byte 0 in the lowest lane.
	typedef logic [PatternSlots-1:0][7:0] pattern_t;

	// One result item on its way to the output.
	typedef struct packed {
		logic found;
		logic [AddrW-1:0] match_address;
	} result_t;

endpackage

// ----- hdl/masked_byte_pattern_search_top.sv -----
// Top level of the masked byte pattern search: registers, window, control.
// Depends on mbps_pkg, mbps_cell and mbps_out_skid.
//
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   data_byte in s_tdata, last_byte in s_tlast
// m_*       out        m_tvalid/m_tready   match_address in m_tdata, found in m_tuser
// cfg_*     in         cfg_valid/cfg_ready register index and write data
//
// One byte is taken per cycle while s_tready is high. A result is registered at
// the edge that takes its byte, into the output register or the skid entry; the
// window test and address add sit in front of it, in the cycle of the byte transfer.
// The reset clears the control state and the registers to their reset values.
// Input stalls only while both entries of the output stage are full.
// Configuration writes are always ready and take effect the next cycle.
module masked_byte_pattern_search_top #(
	parameter int MAX_PATTERN = mbps_pkg::MaxPattern
) (
	input  logic clk,
	input  logic arst_n,
	// Input byte stream.
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic s_tlast,         // last_byte
	// Result stream.
	output logic m_tvalid,
	input  logic m_tready,
	output logic [63:0] m_tdata,  // [63:0] match_address
	output logic m_tuser,         // [0] found
	// Configuration writes.
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [mbps_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [mbps_pkg::AddrW-1:0] cfg_data
);
	import mbps_pkg::*;

	localparam int FillW = $clog2(MAX_PATTERN + 1);
	localparam int LenLimit = (MAX_PATTERN < PatternSlots) ? MAX_PATTERN : PatternSlots;
	localparam logic [LenW-1:0] LenLimitW = LenW'(LenLimit);
	localparam logic [FillW-1:0] FillMax = FillW'(MAX_PATTERN);
	localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

	// Configuration registers.
	logic [AddrW-1:0] pattern_a_q;
	logic [AddrW-1:0] pattern_b_q;
	logic [AddrW-1:0] pattern_c_q;
	logic [CareW-1:0] care_q;
	logic [LenW-1:0] length_q;
	logic [AddrW-1:0] base_q;

	// Search state.
	logic [FillW-1:0] fill_q;
	logic [PosW-1:0] position_q;
	logic finished_q;

	logic accept;
	logic active;
	logic [LenW-1:0] len_eff;
	logic [FillW-1:0] fill_next;
	logic window_full;
	logic all_hit;
	logic match;
	logic [PosW-1:0] start_offset;
	pattern_t pattern;
	logic [7:0] win_in [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] cell_hit;
	logic push;
	logic push_ready;
	result_t push_data;
	result_t out_data;

	assign cfg_ready = 1'b1;

	// Register writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_a_q <= '0;
			pattern_b_q <= '0;
			pattern_c_q <= '0;
			care_q <= '0;
			length_q <= LenW'(1);
			base_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegPatternA: pattern_a_q <= cfg_data;
				RegPatternB: pattern_b_q <= cfg_data;
				RegPatternC: pattern_c_q <= cfg_data;
				RegCareMask: care_q <= cfg_data[CareW-1:0];
				RegPatternLen: length_q <= cfg_data[LenW-1:0];
				RegRegionBase: base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pattern = pattern_t'({pattern_c_q, pattern_b_q, pattern_a_q});

	// Length in use: zero acts as one, and it is capped by the window depth and the pattern slot count.
	always_comb begin
		if (length_q == '0) begin
			len_eff = LenW'(1);
		end else if (length_q > LenLimitW) begin
			len_eff = LenLimitW;
		end else begin
			len_eff = length_q;
		end
	end

	assign accept = s_tvalid && s_tready;
	assign active = accept && !finished_q;

	// Row of window cells, newest byte entering cell 0.
	assign win_in[0] = s_tdata;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		if (j < MAX_PATTERN - 1) begin : g_link
			mbps_cell #(.INDEX(j)) u_cell (
				.clk(clk),
				.shift_en(active),
				.shift_in(win_in[j]),
				.len_eff(len_eff),
				.pattern(pattern),
				.care(care_q),
				.byte_out(win_in[j+1]),
				.hit(cell_hit[j])
			);
		end else begin : g_end
			mbps_cell #(.INDEX(j)) u_cell (
				.clk(clk),
				.shift_en(active),
				.shift_in(win_in[j]),
				.len_eff(len_eff),
				.pattern(pattern),
				.care(care_q),
				.byte_out(),
				.hit(cell_hit[j])
			);
		end
	end

	// Window test after the shift: enough bytes seen and every cell agrees.
	assign fill_next = (fill_q == FillMax) ? fill_q : fill_q + FillW'(1);
	assign window_full = int'(fill_next) >= int'(len_eff);
	assign all_hit = &cell_hit;
	assign match = window_full && all_hit;

	// Offset of the match start and the result item.
	assign start_offset = position_q - PosW'(len_eff - LenW'(1));
	assign push = active && (match || s_tlast);
	assign push_data.found = match;
	assign push_data.match_address = match ? base_q + AddrW'(start_offset) : '0;

	// Region state: count bytes, stop after a result, re-arm on the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			position_q <= '0;
			finished_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				fill_q <= '0;
				position_q <= '0;
				finished_q <= 1'b0;
			end else if (!finished_q) begin
				fill_q <= fill_next;
				if (position_q != PosMax) begin
					position_q <= position_q + PosW'(1);
				end
				finished_q <= match;
			end
		end
	end

	mbps_out_skid u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.push_ready(push_ready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(out_data)
	);

	assign s_tready = push_ready;
	assign m_tdata = out_data.match_address;
	assign m_tuser = out_data.found;

endmodule

// ----- hdl/mbps_cell.sv -----
// One cell of the sliding byte window: holds one byte and compares it.
// Depends on mbps_pkg for the pattern type and widths.
module mbps_cell #(
	parameter int INDEX = 0
) (
	input  logic clk,
	input  logic shift_en,
	input  logic [7:0] shift_in,
	input  logic [mbps_pkg::LenW-1:0] len_eff,
	input  mbps_pkg::pattern_t pattern,
	input  logic [mbps_pkg::CareW-1:0] care,
	output logic [7:0] byte_out,
	output logic hit
);
	import mbps_pkg::*;

	logic [7:0] byte_q;
	logic in_use;
	logic [LenW-1:0] slot;

	// The byte moves one cell further from the newest end on every shift.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= shift_in;
		end
	end

	assign byte_out = byte_q;

	// Cell INDEX lines up with pattern byte len-1-INDEX. The test runs on the
	// byte this cell will hold after the shift, so it sees the new window.
	assign in_use = int'(len_eff) > INDEX;
	assign slot = len_eff - LenW'(1) - LenW'(INDEX);

	always_comb begin
		if (in_use && care[slot]) begin
			hit = (shift_in == pattern[slot]);
		end else begin
			hit = 1'b1;
		end
	end

endmodule

// ----- hdl/mbps_out_skid.sv -----
// Two-entry output stage for result items: an output register and a skid.
// Depends on mbps_pkg for the result type.
module mbps_out_skid (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  mbps_pkg::result_t push_data,
	output logic push_ready,
	output logic out_valid,
	input  logic out_ready,
	output mbps_pkg::result_t out_data
);
	import mbps_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;

	// A new result is taken while the skid entry is free.
	assign push_ready = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves from the skid to the output, straight into the output, or into the skid.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_valid_q || out_ready) begin
			out_data_q <= push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule
